FILE: rtl/cas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cas_pkg: shared types and constants for the complex add/subtract/divide unit
// Item formats, status and operation codes, and register indexes.
// ----------------------------------------------------------------------------
package cas_pkg;

   // fixed-point format and field widths
   localparam int FRAC_BITS = 16;
   localparam int OPER_W    = 16;
   localparam int Q_W       = 32;
   localparam int CSR_IDX_W = 1;

   // status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_DIV_ZERO = 2'd1;
   localparam logic [1:0] ST_SAT      = 2'd2;

   // operation bits: high bit selects divide, low bit subtract
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_DIV = 2'd2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_REAL = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_IMAG = 1'd1;

   // saturation bounds
   localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
   localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

   typedef struct packed {
      logic [1:0]              op;
      logic signed [Q_W-1:0]   second_real;
      logic signed [Q_W-1:0]   second_imag;
   } req_type;

   typedef struct packed {
      logic signed [Q_W-1:0]   result_real;
      logic signed [Q_W-1:0]   result_imag;
      logic [1:0]              status;
   } rsp_type;

endpackage

FILE: rtl/complex_add_sub_divide.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_add_sub_divide: pipelined complex arithmetic unit
// Combines a configured integer operand a+bi with a fixed-point item c+di:
// sum, difference or quotient, saturated to 32 bits with a status code.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | op, second_real, second_imag
//  rsp     | out       | rsp_valid/rsp_stall | result_real, result_imag, status
//  csr     | in        | csr_valid/csr_ready | csr_index, csr_data (16 bit)
//
// One item enters per cycle while the output is not stalled. The stages are a
// multiply stage, a sum stage, a normalize/compare stage, 32 one-bit restoring
// divide stages (one quotient bit each, real and imaginary lanes side by side)
// and the output register. Reset clears the valid bits and the two configuration
// registers; data registers are not reset. A stall on a valid rsp item holds the
// whole pipeline and stalls req in the same cycle.
// ----------------------------------------------------------------------------
module complex_add_sub_divide (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  cas_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output cas_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [cas_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cas_pkg::OPER_W-1:0]     csr_data
);
   import cas_pkg::*;

   localparam int PROD_W = OPER_W + Q_W;
   localparam int MAG_W  = PROD_W;
   localparam int NUM_W  = PROD_W + 1;
   localparam int DEN_W  = 2 * Q_W;
   localparam int SUM_W  = ((OPER_W + FRAC_BITS > Q_W) ? OPER_W + FRAC_BITS : Q_W) + 1;
   localparam int N_W    = MAG_W + 2 * FRAC_BITS;
   localparam int STEPS  = Q_W;

   typedef struct packed {
      logic              v;
      logic              div;
      logic              zero;
      logic              neg_re;
      logic              neg_im;
      logic              ovf_re;
      logic              ovf_im;
      logic [DEN_W-1:0]  den;
      logic [DEN_W-1:0]  r_re;
      logic [DEN_W-1:0]  r_im;
      logic [Q_W-1:0]    n_re;
      logic [Q_W-1:0]    n_im;
      logic [Q_W-1:0]    q_re;
      logic [Q_W-1:0]    q_im;
      logic [Q_W-1:0]    as_re;
      logic [Q_W-1:0]    as_im;
      logic              as_sat;
   } pipe_type;

   // one restoring divide step: returns {quotient bit, new remainder}
   function automatic logic [DEN_W:0] div_bit(input logic [DEN_W-1:0] r,
                                               input logic nbit,
                                               input logic [DEN_W-1:0] den);
      logic [DEN_W:0] t;
      logic [DEN_W:0] d;
      logic           ge;
      t  = {r, nbit};
      d  = {1'b0, den};
      ge = (t >= d);
      if (ge) begin
         d = t - d;
      end else begin
         d = t;
      end
      return {ge, d[DEN_W-1:0]};
   endfunction

   // final sign and saturation of one quotient lane: {sat, value}
   function automatic logic [Q_W:0] lane_out(input logic neg, input logic ovf,
                                              input logic [Q_W-1:0] q);
      logic sat;
      sat = ovf || (!neg && q[Q_W-1]) || (neg && (q > Q_MIN));
      if (sat) begin
         return {1'b1, (neg ? Q_MIN : Q_MAX)};
      end
      return {1'b0, (neg ? (~q + 1'b1) : q)};
   endfunction

   logic                      adv;
   logic signed [OPER_W-1:0]  first_real_ff, first_imag_ff;

   // configuration registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         first_real_ff <= '0;
         first_imag_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_FIRST_REAL) first_real_ff <= csr_data;
         if (csr_index == CSR_FIRST_IMAG) first_imag_ff <= csr_data;
      end
   end

   // whole pipeline advances unless a finished item is held at the output
   logic rsp_valid_ff;
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign rsp_valid = rsp_valid_ff;

   // stage 1: products and add/subtract
   logic                     s1_v_ff, s1_div_ff;
   logic signed [PROD_W-1:0] s1_ac_ff, s1_bd_ff, s1_bc_ff, s1_ad_ff;
   logic [DEN_W-2:0]         s1_cc_ff, s1_dd_ff;
   logic signed [SUM_W-1:0]  s1_sum_re_ff, s1_sum_im_ff;
   logic signed [DEN_W-1:0]  cc_full, dd_full;
   logic signed [SUM_W-1:0]  a_sh, b_sh, s1_sum_re_in, s1_sum_im_in;

   always_comb begin
      cc_full = DEN_W'(req_data.second_real) * DEN_W'(req_data.second_real);
      dd_full = DEN_W'(req_data.second_imag) * DEN_W'(req_data.second_imag);
      a_sh    = SUM_W'(first_real_ff) <<< FRAC_BITS;
      b_sh    = SUM_W'(first_imag_ff) <<< FRAC_BITS;
      if ((req_data.op & OP_SUB) != 2'd0) begin
         s1_sum_re_in = a_sh - SUM_W'(req_data.second_real);
         s1_sum_im_in = b_sh - SUM_W'(req_data.second_imag);
      end else begin
         s1_sum_re_in = a_sh + SUM_W'(req_data.second_real);
         s1_sum_im_in = b_sh + SUM_W'(req_data.second_imag);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_div_ff    <= (req_data.op & OP_DIV) != 2'd0;
         s1_ac_ff     <= PROD_W'(first_real_ff) * PROD_W'(req_data.second_real);
         s1_bd_ff     <= PROD_W'(first_imag_ff) * PROD_W'(req_data.second_imag);
         s1_bc_ff     <= PROD_W'(first_imag_ff) * PROD_W'(req_data.second_real);
         s1_ad_ff     <= PROD_W'(first_real_ff) * PROD_W'(req_data.second_imag);
         s1_cc_ff     <= cc_full[DEN_W-2:0];
         s1_dd_ff     <= dd_full[DEN_W-2:0];
         s1_sum_re_ff <= s1_sum_re_in;
         s1_sum_im_ff <= s1_sum_im_in;
      end
   end

   // stage 2: numerators, denominator, clamp of add/subtract
   logic                     s2_v_ff, s2_div_ff, s2_as_sat_ff;
   logic signed [NUM_W-1:0]  s2_num_re_ff, s2_num_im_ff;
   logic [DEN_W-1:0]         s2_den_ff;
   logic [Q_W-1:0]           s2_as_re_ff, s2_as_im_ff;
   logic                     sat_re_hi, sat_re_lo, sat_im_hi, sat_im_lo;
   logic [Q_W-1:0]           as_re_in, as_im_in;

   always_comb begin
      sat_re_hi = s1_sum_re_ff > SUM_W'(Q_MAX);
      sat_re_lo = s1_sum_re_ff < SUM_W'(Q_MIN);
      sat_im_hi = s1_sum_im_ff > SUM_W'(Q_MAX);
      sat_im_lo = s1_sum_im_ff < SUM_W'(Q_MIN);
      as_re_in  = sat_re_hi ? Q_MAX : (sat_re_lo ? Q_MIN : s1_sum_re_ff[Q_W-1:0]);
      as_im_in  = sat_im_hi ? Q_MAX : (sat_im_lo ? Q_MIN : s1_sum_im_ff[Q_W-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (adv) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_div_ff    <= s1_div_ff;
         s2_num_re_ff <= NUM_W'(s1_ac_ff) + NUM_W'(s1_bd_ff);
         s2_num_im_ff <= NUM_W'(s1_bc_ff) - NUM_W'(s1_ad_ff);
         s2_den_ff    <= DEN_W'(s1_cc_ff) + DEN_W'(s1_dd_ff);
         s2_as_re_ff  <= as_re_in;
         s2_as_im_ff  <= as_im_in;
         s2_as_sat_ff <= sat_re_hi | sat_re_lo | sat_im_hi | sat_im_lo;
      end
   end

   // stage 3: magnitudes, overflow check, remainder seed
   pipe_type                p_ff [0:STEPS];
   pipe_type                p_in [0:STEPS];
   logic signed [NUM_W-1:0] neg_re_full, neg_im_full;
   logic [MAG_W-1:0]        mag_re, mag_im;
   logic [N_W-1:0]          nn_re, nn_im;
   logic [DEN_W-1:0]        hi_re, hi_im;

   always_comb begin
      neg_re_full = -s2_num_re_ff;
      neg_im_full = -s2_num_im_ff;
      mag_re = s2_num_re_ff[NUM_W-1] ? neg_re_full[MAG_W-1:0] : s2_num_re_ff[MAG_W-1:0];
      mag_im = s2_num_im_ff[NUM_W-1] ? neg_im_full[MAG_W-1:0] : s2_num_im_ff[MAG_W-1:0];
      nn_re  = {mag_re, {(2*FRAC_BITS){1'b0}}};
      nn_im  = {mag_im, {(2*FRAC_BITS){1'b0}}};
      hi_re  = DEN_W'(nn_re[N_W-1:Q_W]);
      hi_im  = DEN_W'(nn_im[N_W-1:Q_W]);
      p_in[0]        = '0;
      p_in[0].v      = s2_v_ff;
      p_in[0].div    = s2_div_ff;
      p_in[0].zero   = (s2_den_ff == '0);
      p_in[0].neg_re = s2_num_re_ff[NUM_W-1];
      p_in[0].neg_im = s2_num_im_ff[NUM_W-1];
      p_in[0].ovf_re = (hi_re >= s2_den_ff);
      p_in[0].ovf_im = (hi_im >= s2_den_ff);
      p_in[0].den    = s2_den_ff;
      p_in[0].r_re   = hi_re;
      p_in[0].r_im   = hi_im;
      p_in[0].n_re   = nn_re[Q_W-1:0];
      p_in[0].n_im   = nn_im[Q_W-1:0];
      p_in[0].as_re  = s2_as_re_ff;
      p_in[0].as_im  = s2_as_im_ff;
      p_in[0].as_sat = s2_as_sat_ff;
   end

   // divide stages: one quotient bit per lane per stage
   for (genvar k = 0; k < STEPS; k++) begin : g_div
      logic [DEN_W:0] st_re, st_im;
      always_comb begin
         st_re      = div_bit(p_ff[k].r_re, p_ff[k].n_re[Q_W-1], p_ff[k].den);
         st_im      = div_bit(p_ff[k].r_im, p_ff[k].n_im[Q_W-1], p_ff[k].den);
         p_in[k+1]      = p_ff[k];
         p_in[k+1].r_re = st_re[DEN_W-1:0];
         p_in[k+1].r_im = st_im[DEN_W-1:0];
         p_in[k+1].n_re = {p_ff[k].n_re[Q_W-2:0], 1'b0};
         p_in[k+1].n_im = {p_ff[k].n_im[Q_W-2:0], 1'b0};
         p_in[k+1].q_re = {p_ff[k].q_re[Q_W-2:0], st_re[DEN_W]};
         p_in[k+1].q_im = {p_ff[k].q_im[Q_W-2:0], st_im[DEN_W]};
      end
   end

   // stage registers: only the valid bit is reset
   for (genvar k = 0; k <= STEPS; k++) begin : g_pipe
      always_ff @(posedge clock) begin
         if (reset) begin
            p_ff[k].v <= 1'b0;
         end else if (adv) begin
            p_ff[k].v <= p_in[k].v;
         end
         if (adv) begin
            p_ff[k][$bits(pipe_type)-2:0] <= p_in[k][$bits(pipe_type)-2:0];
         end
      end
   end

   // output stage: sign, saturation, status
   rsp_type    rsp_ff, rsp_in;
   logic [Q_W:0] lo_re, lo_im;

   always_comb begin
      lo_re = lane_out(p_ff[STEPS].neg_re, p_ff[STEPS].ovf_re, p_ff[STEPS].q_re);
      lo_im = lane_out(p_ff[STEPS].neg_im, p_ff[STEPS].ovf_im, p_ff[STEPS].q_im);
      if (!p_ff[STEPS].div) begin
         rsp_in.result_real = p_ff[STEPS].as_re;
         rsp_in.result_imag = p_ff[STEPS].as_im;
         rsp_in.status      = p_ff[STEPS].as_sat ? ST_SAT : ST_OK;
      end else if (p_ff[STEPS].zero) begin
         rsp_in.result_real = '0;
         rsp_in.result_imag = '0;
         rsp_in.status      = ST_DIV_ZERO;
      end else begin
         rsp_in.result_real = lo_re[Q_W-1:0];
         rsp_in.result_imag = lo_im[Q_W-1:0];
         rsp_in.status      = (lo_re[Q_W] | lo_im[Q_W]) ? ST_SAT : ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= p_ff[STEPS].v;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

FILE: rtl/cas_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cas_checker: port-level checks for the complex add/subtract/divide unit
// Watches the top level's ports and is bound to it below.
// ----------------------------------------------------------------------------
module cas_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  cas_pkg::req_type               req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  cas_pkg::rsp_type               rsp_data
);
   import cas_pkg::*;

   // a held item keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp item changed while stalled");

   // input is only held off by a blocked output item
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req stalled without rsp backpressure");

   // zero divisor gives zero parts
   a_div_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_DIV_ZERO |->
         rsp_data.result_real == '0 && rsp_data.result_imag == '0)
      else $error("divide by zero with nonzero result");

   // saturation status means a part sits at a bound
   a_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_SAT |->
         rsp_data.result_real == Q_MAX || rsp_data.result_real == Q_MIN ||
         rsp_data.result_imag == Q_MAX || rsp_data.result_imag == Q_MIN)
      else $error("saturation status without a clamped part");

endmodule

bind complex_add_sub_divide cas_checker u_cas_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

FILE: bench/tb_complex_add_sub_divide.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_complex_add_sub_divide: self-checking bench for the complex arithmetic unit
// Drives add, subtract and divide items under several first-operand settings.
// Random sender bursts and receiver stalls are applied in parts of the random
// and backpressure tests. A local predictor computes each expected result, and
// every result is checked in order against it.
// ----------------------------------------------------------------------------
module tb_complex_add_sub_divide;
   import cas_pkg::*;

   localparam logic [1:0] OP_ADD     = 2'd0;
   localparam logic [1:0] OP_DIV_ALT = 2'd3;
   localparam logic [63:0] QUOT_CAP  = 64'd1 << 40;
   localparam int DRAIN_CYCLES       = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_FIRST_REAL;
   logic [OPER_W-1:0] csr_data = '0;

   // local copy of the first operand
   logic signed [15:0] first_re = '0;
   logic signed [15:0] first_im = '0;

   rsp_type result_q[$];
   int error_count = 0;
   int stall_mode = 0;
   int hold_cycles = 0;
   int burst_left = 0;

   complex_add_sub_divide u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   initial begin
      #20ms;
      $display("tb_complex_add_sub_divide: errors");
      $finish;
   end

   // |num| * 2^32 / den truncated, held at the cap, sign of num restored
   function automatic logic signed [63:0] scaled_quotient(logic signed [63:0] num,
                                                          logic [63:0] den);
      logic neg;
      logic [63:0] mag, rem, quo;
      logic nbit;
      int i;
      neg = num[63];
      mag = neg ? -num : num;
      rem = '0;
      quo = '0;
      for (i = 95; i >= 0; i--) begin
         nbit = (i >= 32) ? mag[i-32] : 1'b0;
         rem = {rem[62:0], nbit};
         quo = {quo[62:0], 1'b0};
         if (rem >= den) begin
            rem = rem - den;
            quo[0] = 1'b1;
         end
         if (quo > QUOT_CAP) quo = QUOT_CAP;
      end
      return neg ? -$signed(quo) : $signed(quo);
   endfunction

   function automatic logic signed [63:0] clamp_q(logic signed [63:0] x, ref logic sat);
      if (x > 64'sd2147483647) begin
         sat = 1'b1;
         return 64'sd2147483647;
      end
      if (x < -64'sd2147483648) begin
         sat = 1'b1;
         return -64'sd2147483648;
      end
      return x;
   endfunction

   function automatic rsp_type predict_result(req_type r);
      logic signed [63:0] a, b, c, d, re, im;
      logic [63:0] den;
      logic sat;
      rsp_type o;
      a = first_re;
      b = first_im;
      c = r.second_real;
      d = r.second_imag;
      sat = 1'b0;
      o.status = ST_OK;
      if (r.op[1]) begin
         den = c * c + d * d;
         if (den == 0) begin
            re = 0;
            im = 0;
            o.status = ST_DIV_ZERO;
         end else begin
            re = scaled_quotient(a * c + b * d, den);
            im = scaled_quotient(b * c - a * d, den);
         end
      end else if (r.op[0]) begin
         re = (a <<< FRAC_BITS) - c;
         im = (b <<< FRAC_BITS) - d;
      end else begin
         re = (a <<< FRAC_BITS) + c;
         im = (b <<< FRAC_BITS) + d;
      end
      re = clamp_q(re, sat);
      im = clamp_q(im, sat);
      if (o.status == ST_OK && sat) o.status = ST_SAT;
      o.result_real = re[31:0];
      o.result_imag = im[31:0];
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // result checker: values at the falling edge hold for the next rising edge
   always @(negedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (result_q.size() == 0) begin
            report_mismatch("unexpected item", rsp_data.result_real, '0);
         end else begin
            want = result_q.pop_front();
            if (rsp_data.result_real !== want.result_real)
               report_mismatch("result_real", rsp_data.result_real, want.result_real);
            if (rsp_data.result_imag !== want.result_imag)
               report_mismatch("result_imag", rsp_data.result_imag, want.result_imag);
            if (rsp_data.status !== want.status)
               report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
         end
      end
   end

   // receiver stall pattern, with an optional long hold-off
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else if (stall_mode == 0) begin
         rsp_stall <= 1'b0;
      end else if (stall_mode == 1) begin
         rsp_stall <= ($urandom_range(0, 3) == 0);
      end else begin
         rsp_stall <= ($urandom_range(0, 1) == 0);
      end
   end

   // offer one item and hold it until accepted
   task automatic send_item(logic [1:0] op, logic [31:0] cr, logic [31:0] ci, bit gaps);
      req_type r;
      logic stalled;
      int gap;
      if (gaps && burst_left == 0) begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 20);
      end
      if (burst_left > 0) burst_left--;
      r.op = op;
      r.second_real = cr;
      r.second_imag = ci;
      req_valid <= 1'b1;
      req_data <= r;
      do begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
      end while (stalled);
      result_q.push_back(predict_result(r));
   endtask

   task automatic stop_sending();
      req_valid <= 1'b0;
   endtask

   // pause until every result is back, then let the pipeline settle
   task automatic wait_drain();
      stop_sending();
      while (result_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [15:0] value);
      logic ready;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do begin
         @(negedge clock);
         ready = csr_ready;
         @(posedge clock);
      end while (!ready);
      csr_valid <= 1'b0;
      if (idx == CSR_FIRST_REAL) first_re = value;
      else first_im = value;
   endtask

   task automatic set_first(logic [15:0] re, logic [15:0] im);
      write_csr(CSR_FIRST_REAL, re);
      write_csr(CSR_FIRST_IMAG, im);
   endtask

   // operand shapes: full range, small Q16.16 values, extremes, zero
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 5))
         0, 1: return $urandom;
         2: return $signed($urandom_range(0, 64)) - 32 <<< 16;
         3: return $signed($urandom_range(0, 2000000)) - 1000000;
         4: return ($urandom_range(0, 1)) ? 32'h7fffffff : 32'h80000000;
         default: return ($urandom_range(0, 1)) ? 32'd0 : $urandom_range(0, 7);
      endcase
   endfunction

   function automatic logic [1:0] pick_op();
      case ($urandom_range(0, 6))
         0, 1: return OP_ADD;
         2, 3: return OP_SUB;
         4, 5: return OP_DIV;
         default: return OP_DIV_ALT;
      endcase
   endfunction

   task automatic run_random(int count);
      logic [31:0] cr, ci;
      int i;
      for (i = 0; i < count; i++) begin
         cr = pick_operand();
         ci = ($urandom_range(0, 9) == 0) ? 32'd0 : pick_operand();
         send_item(pick_op(), cr, ci, 1'b1);
      end
   endtask

   task automatic test_directed();
      set_first(16'sd3, -16'sd2);
      send_item(OP_ADD, 32'h7fffffff, 32'h80000000, 1'b0);
      send_item(OP_ADD, 32'h0001_8000, 32'hffff_0000, 1'b0);
      send_item(OP_SUB, 32'h80000000, 32'h7fffffff, 1'b0);
      send_item(OP_SUB, 32'h0003_0000, 32'hfffe_0000, 1'b0);
      send_item(OP_DIV, 32'd0, 32'd0, 1'b0);
      send_item(OP_DIV_ALT, 32'd0, 32'd0, 1'b0);
      send_item(OP_DIV, 32'h0001_0000, 32'd0, 1'b0);
      send_item(OP_DIV_ALT, 32'h0002_0000, 32'h0001_0000, 1'b0);
      send_item(OP_DIV, 32'h7fffffff, 32'h7fffffff, 1'b0);
      send_item(OP_DIV, 32'h80000000, 32'h80000000, 1'b0);
      send_item(OP_DIV, 32'd1, 32'd0, 1'b0);
      send_item(OP_DIV, 32'hffffffff, 32'd1, 1'b0);
      send_item(OP_DIV, 32'h0000_8000, 32'hffff_8000, 1'b0);
      wait_drain();
      set_first(16'h7fff, 16'h8000);
      send_item(OP_ADD, 32'h7fffffff, 32'h80000000, 1'b0);
      send_item(OP_SUB, 32'h80000000, 32'h7fffffff, 1'b0);
      send_item(OP_SUB, 32'hffffffff, 32'd1, 1'b0);
      send_item(OP_DIV, 32'd1, 32'd1, 1'b0);
      send_item(OP_DIV, 32'h0001_0000, 32'h0001_0000, 1'b0);
      send_item(OP_DIV_ALT, 32'h5555aaaa, 32'haaaa5555, 1'b0);
      wait_drain();
   endtask

   task automatic test_random_settings();
      stall_mode = 1;
      set_first(16'h8000, 16'h7fff);
      run_random(200);
      wait_drain();
      stall_mode = 2;
      set_first(16'd0, 16'd0);
      run_random(150);
      wait_drain();
      stall_mode = 0;
      set_first(16'($urandom), 16'($urandom));
      run_random(150);
      wait_drain();
      stall_mode = 1;
      set_first(16'($urandom_range(0, 20) - 10), 16'($urandom_range(0, 20) - 10));
      run_random(200);
      wait_drain();
   endtask

   // receiver holds off long enough for the pipeline to fill and stall req
   task automatic test_backpressure();
      int i;
      stall_mode = 1;
      set_first(16'sd1, 16'sd1);
      hold_cycles <= 300;
      @(posedge clock);
      for (i = 0; i < 100; i++) send_item(pick_op(), pick_operand(), pick_operand(), 1'b0);
      wait_drain();
      set_first(16'h8000, 16'h8000);
      run_random(130);
      wait_drain();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_settings();
      test_backpressure();
      if (error_count == 0) begin
         $display("tb_complex_add_sub_divide: clean");
      end else begin
         $display("tb_complex_add_sub_divide: errors");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/cas_pkg.sv
rtl/complex_add_sub_divide.sv
rtl/cas_checker.sv
bench/tb_complex_add_sub_divide.sv
